>>> sv/base64_stream_encoder_assert.svh
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold on every cycle out of reset
`define B64ENC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("b64enc check failed");
// consequent must hold in the cycle after the antecedent
`define B64ENC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64enc check failed");
`else
`define B64ENC_ASSERT(lbl, cond)
`define B64ENC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/b64enc_pkg.sv
// shared types, constants and alphabet lookup for the base64 stream encoder
package b64enc_pkg;

  localparam int QueueDepth = 2;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // input word: one raw byte plus end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  // result word: one output character
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_word_t;

  // one complete or padded three-byte group
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;  // index of the last real character, rest is padding
    logic       fin;
  } grp_t;

  // map a 6-bit slice onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      return c + 8'd65;
    end else if (v < 6'd52) begin
      return c + 8'd71;
    end else if (v < 6'd62) begin
      return c - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

>>> sv/b64enc_front.sv
// front end: gathers bytes into groups and hands finished groups to the queue
module b64enc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  b64enc_pkg::in_word_t item,
  output logic                 q_push,
  output b64enc_pkg::grp_t     q_word,
  input  logic                 q_full
);
  import b64enc_pkg::*;

  logic [1:0] pos;
  logic [7:0] pend [2];
  logic       accept;

  assign full   = q_full;
  assign accept = push && !full;

  // a group leaves on its third byte or on the message's final byte
  assign q_push = accept && (item.final_byte || (pos == 2'd2));

  // assemble the group from held bytes, this byte and zero fill
  always_comb begin
    q_word.fin = item.final_byte;
    case (pos)
      2'd1: begin
        q_word.b0       = pend[0];
        q_word.b1       = item.data_byte;
        q_word.b2       = 8'h00;
        q_word.last_idx = 2'd2;
      end
      2'd2: begin
        q_word.b0       = pend[0];
        q_word.b1       = pend[1];
        q_word.b2       = item.data_byte;
        q_word.last_idx = 2'd3;
      end
      default: begin
        q_word.b0       = item.data_byte;
        q_word.b1       = 8'h00;
        q_word.b2       = 8'h00;
        q_word.last_idx = 2'd1;
      end
    endcase
  end

  // group position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (accept) begin
      if (q_push) begin
        pos <= 2'd0;
      end else begin
        pos <= (pos == 2'd1) ? 2'd2 : 2'd1;
      end
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (accept && !q_push) begin
      if (pos == 2'd1) begin
        pend[1] <= item.data_byte;
      end else begin
        pend[0] <= item.data_byte;
      end
    end
  end

endmodule

>>> sv/b64enc_queue.sv
// short group queue between the front and back ends
module b64enc_queue #(
  parameter int DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  b64enc_pkg::grp_t wr_word,
  output logic             q_full,
  input  logic             rd_en,
  output b64enc_pkg::grp_t rd_word,
  output logic             q_valid
);
  import b64enc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  grp_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (count == FullCnt);
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_word = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/b64enc_back.sv
// back end: turns one group into four characters, one per cycle while pop is high
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  b64enc_pkg::grp_t      q_word,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_word_t result
);
  import b64enc_pkg::*;

  grp_t       grp;
  logic       grp_valid;
  logic [1:0] idx;
  logic [5:0] slice;
  logic       take;

  assign empty = !grp_valid;
  assign take  = pop && grp_valid;
  assign q_pop = q_valid && (!grp_valid || (take && (idx == 2'd3)));

  // pick the 6-bit slice for the current character
  always_comb begin
    case (idx)
      2'd0:    slice = grp.b0[7:2];
      2'd1:    slice = {grp.b0[1:0], grp.b1[7:4]};
      2'd2:    slice = {grp.b1[3:0], grp.b2[7:6]};
      default: slice = grp.b2[5:0];
    endcase
  end

  // result word
  assign result.out_char    = (idx > grp.last_idx) ? PAD_CHAR : b64_char(slice);
  assign result.run_last    = (idx == 2'd3);
  assign result.message_end = (idx == 2'd3) && grp.fin;

  // current group and character index
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (idx == 2'd3) begin
        grp_valid <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp <= q_word;
    end
  end

endmodule

>>> sv/base64_stream_encoder.sv
// top level of the streaming base64 encoder
//
// Input channel: one raw byte per word with a flag on the message's last
// byte; a word is taken when push is high and full is low. Result channel:
// one ASCII character per word; while empty is low the oldest character
// sits on result and is taken when pop is high.
// Each third byte of a group, or a final byte, produces a run of four
// characters; run_last marks the fourth, message_end marks the end of the
// message. Partial groups are zero-filled and padded with '='.
// The group closed by a byte passes through the queue and into the back
// end's group register before its first character is on result. The back
// end gives one character per cycle while pop is high, so sustained
// throughput is set by the result side: four characters per group.
// Bytes that do not close a group are taken every cycle while the queue
// of QUEUE_DEPTH groups has room; full rises only when that queue is full,
// as on a receiver stall or a long message. Nothing is lost on a stall.
// Reset clears the group position, the queue and the output stage; an
// empty message produces no characters.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  b64enc_pkg::in_word_t  item,
  output logic                  empty,
  input  logic                  pop,
  output b64enc_pkg::out_word_t result
);
  import b64enc_pkg::*;

  `include "base64_stream_encoder_assert.svh"

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  grp_t q_in;
  grp_t q_out;

  // byte gathering
  b64enc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_word (q_in),
    .q_full (q_full)
  );

  // group queue
  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_word (q_in),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_word (q_out),
    .q_valid (q_valid)
  );

  // character output
  b64enc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // a group is never offered to a full queue
  `B64ENC_ASSERT(a_no_push_when_full, !(q_push && q_full))
  // a run keeps its characters coming until its last one is taken
  `B64ENC_ASSERT_NEXT(a_run_continues, pop && !empty && !result.run_last, !empty)
  // message end only closes a run
  `B64ENC_ASSERT(a_end_on_last, empty || !result.message_end || result.run_last)

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the streaming base64 encoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64enc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 200;
  localparam logic [31:0] PREDICT_ONLY = 32'h0;

  // one directed row: input word plus typed characters, or PREDICT_ONLY
  typedef struct packed {
    in_word_t    word;
    logic [31:0] typed;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 21;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // single-byte messages at the extremes
    {8'h00, 1'b1, "AA=="},
    {8'hFF, 1'b1, "/w=="},
    // two-byte message, all ones
    {8'hFF, 1'b0, PREDICT_ONLY},
    {8'hFF, 1'b1, "//8="},
    // full group that does not end the message, then a closing group
    {8'hFF, 1'b0, PREDICT_ONLY},
    {8'hFF, 1'b0, PREDICT_ONLY},
    {8'hFF, 1'b0, "////"},
    {8'h00, 1'b0, PREDICT_ONLY},
    {8'h00, 1'b0, PREDICT_ONLY},
    {8'h00, 1'b1, "AAAA"},
    // "Man" and "Ma"
    {8'h4D, 1'b0, PREDICT_ONLY},
    {8'h61, 1'b0, PREDICT_ONLY},
    {8'h6E, 1'b1, "TWFu"},
    {8'h4D, 1'b0, PREDICT_ONLY},
    {8'h61, 1'b1, "TWE="},
    // every slice 62
    {8'hFB, 1'b0, PREDICT_ONLY},
    {8'hEF, 1'b0, PREDICT_ONLY},
    {8'hBE, 1'b1, "++++"},
    // alternating bit patterns, checked against the predictor
    {8'hAA, 1'b0, PREDICT_ONLY},
    {8'h55, 1'b0, PREDICT_ONLY},
    {8'h0F, 1'b1, PREDICT_ONLY}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  item = '0;
  logic      full;
  logic      empty;
  out_word_t result;

  // encoder model state
  string      b64_digits = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                            "0123456789+/"};
  logic [7:0] held_bytes [2];
  logic [1:0] group_fill = 2'd0;
  out_word_t  expected_chars [$];

  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned chars_taken = 0;

  base64_stream_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_stream_encoder verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned idx,
                                 input logic [9:0] want, input logic [9:0] got);
    $display("mismatch: %s at char %0d: expected %h got %h", what, idx, want, got);
    err_count++;
  endtask

  // advance the encoder model by one accepted byte and queue its characters
  function automatic void encode_byte(input in_word_t w, input logic [31:0] typed);
    logic [7:0] b0, b1, b2;
    logic [5:0] slices [4];
    int         n_real;
    out_word_t  ch;
    if (!w.final_byte && group_fill < 2'd2) begin
      held_bytes[group_fill[0]] = w.data_byte;
      group_fill = group_fill + 2'd1;
      return;
    end
    // assemble the group with zero fill
    case (group_fill)
      2'd0: begin
        b0 = w.data_byte;
        b1 = 8'h00;
        b2 = 8'h00;
        n_real = 2;
      end
      2'd1: begin
        b0 = held_bytes[0];
        b1 = w.data_byte;
        b2 = 8'h00;
        n_real = 3;
      end
      default: begin
        b0 = held_bytes[0];
        b1 = held_bytes[1];
        b2 = w.data_byte;
        n_real = 4;
      end
    endcase
    slices[0] = b0[7:2];
    slices[1] = {b0[1:0], b1[7:4]};
    slices[2] = {b1[3:0], b2[7:6]};
    slices[3] = b2[5:0];
    for (int i = 0; i < 4; i++) begin
      ch.out_char = (i < n_real) ? b64_digits[slices[i]] : PAD_CHAR;
      if (typed != PREDICT_ONLY) begin
        ch.out_char = typed[31 - 8 * i -: 8];
      end
      ch.run_last = (i == 3);
      ch.message_end = (i == 3) && w.final_byte;
      expected_chars.push_back(ch);
    end
    group_fill = 2'd0;
  endfunction

  // sender: idle a random number of cycles, then offer one word until taken
  int send_burst = 0;

  task automatic offer_word(input in_word_t w, input logic [31:0] typed);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 29) == 0) send_burst = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_byte(w, typed);
  endtask

  // receiver: random pop gaps, two long holds to back the block up
  initial begin
    int gap;
    int recv_burst;
    out_word_t want;
    recv_burst = 0;
    while (rst) @(posedge clk);
    forever begin
      if (chars_taken == 48 || chars_taken == 500) begin
        gap = LONG_HOLD;
      end else if (recv_burst > 0) begin
        recv_burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 29) == 0) recv_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      // compare the accepted word with the oldest expectation
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word", chars_taken, 10'h0, result);
      end else begin
        want = expected_chars.pop_front();
        if (result.out_char !== want.out_char)
          report_mismatch("out_char", chars_taken, want, result);
        if (result.run_last !== want.run_last)
          report_mismatch("run_last", chars_taken, want, result);
        if (result.message_end !== want.message_end)
          report_mismatch("message_end", chars_taken, want, result);
      end
      chars_taken++;
    end
  end

  // main sequence
  initial begin
    int sent;
    int msg_len;
    int drain;
    in_word_t w;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_word(directed_rows[r].word, directed_rows[r].typed);
    end

    // random messages, mostly short, some long
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 7) msg_len = $urandom_range(1, 6);
      else msg_len = $urandom_range(7, 40);
      for (int k = 0; k < msg_len; k++) begin
        case ($urandom_range(0, 9))
          0: w.data_byte = 8'h00;
          1: w.data_byte = 8'hFF;
          default: w.data_byte = 8'($urandom_range(0, 255));
        endcase
        w.final_byte = (k == msg_len - 1);
        offer_word(w, PREDICT_ONLY);
        sent++;
      end
    end
    push <= 1'b0;

    // wait for every expected word, then a few more cycles for strays
    drain = 0;
    while (expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch("expected words never arrived", chars_taken, expected_chars[0],
                      10'h0);
    end

    if (err_count == 0) begin
      $display("base64_stream_encoder verification clean");
    end else begin
      $display("base64_stream_encoder verification failed");
    end
    $finish;
  end

endmodule
